// ===== rtl/core/gzmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gzmh_pkg;

    // header parse phases
    typedef enum logic [2:0] {
        PH_FIXED,
        PH_XLO,
        PH_XHI,
        PH_NAME,
        PH_COMMENT,
        PH_BODY
    } phase_t;

    // byte tags
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_TRAILER = 2'd2;

    // member status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;
    localparam logic [1:0] STATUS_TRUNC     = 2'd3;

    // fixed header bytes
    localparam logic [7:0] MAGIC_ID1  = 8'h1f;
    localparam logic [7:0] MAGIC_ID2  = 8'h8b;
    localparam logic [7:0] CM_DEFLATE = 8'h08;

    // flag bit positions
    localparam int unsigned FLG_FHCRC    = 1;
    localparam int unsigned FLG_FEXTRA   = 2;
    localparam int unsigned FLG_FNAME    = 3;
    localparam int unsigned FLG_FCOMMENT = 4;

    // layout constants
    localparam int unsigned FIXED_HDR_LAST = 9;
    localparam int unsigned FIXED_HDR_LEN  = 10;
    localparam int unsigned TRAILER_LEN    = 8;
    localparam int unsigned ISIZE_LEN      = 4;
    localparam int unsigned MIN_MEMBER_LEN = 18;

    // length register compares, worked out at write time
    typedef struct packed {
        logic zero;
        logic lt4;
        logic lt8;
    } len_flags_t;

    // per item control from the parse stage to the report stage
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       done;
        logic       magic_err;
        logic       trunc;
        logic [2:0] pos_add;
    } item_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/gzip_member_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// gzip member header parser
// s_t* carries the member's bytes in order, one item per byte; every byte comes
// back on m_t* tagged header, payload or trailer in m_tuser, with m_tlast on the
// final byte of the member. On that item m_tdata also holds the status and,
// when it is ok, the payload start, payload length and ISIZE from the trailer.
// The member length is written on cfg_*; the user must do so only while no byte is
// in flight; the block does not enforce it. Throughput is one byte per cycle unless
// m_tready stalls. A byte reaches m_t* through one register after the header walk
// (item tag, header end, ISIZE) and one output register after the status and
// length arithmetic. The walk state is updated once per byte, which sets the
// single-byte rate. A new byte is taken whenever the parse stage is empty or moving
// on, so a byte can enter while a finished item waits on m_tready; a stall holds
// both stages. Reset clears the pipeline, the parse state and the length register
// (zero), and after a final byte the parser starts the next member from its first
// byte. A member with no FNAME/FCOMMENT terminator counts the string as ending one
// byte past the member end.

module gzip_member_header_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    // configuration: member length
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data,      // member_length
    // byte input
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,       // [7:0] data_byte
    // tagged byte output
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,       // [7:0] byte_out, [9:8] status,
                                         // [41:10] payload_start,
                                         // [73:42] payload_length,
                                         // [105:74] original_size, rest zero
    output logic [1:0]    m_tuser,       // [1:0] byte_kind
    output logic          m_tlast        // member_done
);

    localparam int POS_BITS = (LENGTH_BITS >= 63) ? 64 : LENGTH_BITS + 1;

    // length register and derived compares
    logic [LENGTH_BITS-1:0] len_m1_reg, len_m1_next;
    logic [LENGTH_BITS-1:0] len_m4_reg, len_m4_next;
    logic [LENGTH_BITS-1:0] len_m8_reg, len_m8_next;
    gzmh_pkg::len_flags_t   len_flags_reg, len_flags_next;
    logic                   len_lt18_reg, len_lt18_next;
    logic [63:0]            cfg_wide;
    logic [LENGTH_BITS-1:0] len_val;

    // parse stage
    logic                   a_valid;
    logic                   b_ready;
    gzmh_pkg::item_ctl_t    a_ctl;
    logic [POS_BITS-1:0]    a_pos;
    logic [31:0]            a_size;

    // report stage
    logic [POS_BITS:0]      pos_sum;
    logic [POS_BITS-1:0]    pos_fin;
    logic [63:0]            plen_wide;
    logic [1:0]             status_c;
    logic                   ok_c;

    // output registers
    logic                   m_valid_reg;
    logic [7:0]             byte_reg;
    logic [1:0]             kind_reg;
    logic                   last_reg;
    logic [1:0]             status_reg;
    logic [31:0]            pstart_reg;
    logic [31:0]            plen_reg;
    logic [31:0]            isize_reg;

    assign cfg_ready = 1'b1;

    // length compares worked out at write time
    always_comb
    begin
        cfg_wide             = 64'(cfg_data);
        len_val              = cfg_wide[LENGTH_BITS-1:0];
        len_m1_next          = len_m1_reg;
        len_m4_next          = len_m4_reg;
        len_m8_next          = len_m8_reg;
        len_flags_next       = len_flags_reg;
        len_lt18_next        = len_lt18_reg;
        if (cfg_valid && cfg_ready)
        begin
            len_m1_next          = len_val - LENGTH_BITS'(1);
            len_m4_next          = len_val - LENGTH_BITS'(gzmh_pkg::ISIZE_LEN);
            len_m8_next          = len_val - LENGTH_BITS'(gzmh_pkg::TRAILER_LEN);
            len_flags_next.zero  = (len_val == '0);
            len_flags_next.lt4   = (len_val < LENGTH_BITS'(gzmh_pkg::ISIZE_LEN));
            len_flags_next.lt8   = (len_val < LENGTH_BITS'(gzmh_pkg::TRAILER_LEN));
            len_lt18_next        = (len_val < LENGTH_BITS'(gzmh_pkg::MIN_MEMBER_LEN));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_m1_reg    <= '0;
            len_m4_reg    <= '0;
            len_m8_reg    <= '0;
            len_flags_reg <= '{zero: 1'b1, lt4: 1'b1, lt8: 1'b1};
            len_lt18_reg  <= 1'b1;
        end
        else
        begin
            len_m1_reg    <= len_m1_next;
            len_m4_reg    <= len_m4_next;
            len_m8_reg    <= len_m8_next;
            len_flags_reg <= len_flags_next;
            len_lt18_reg  <= len_lt18_next;
        end
    end

    assign b_ready = !m_valid_reg || m_tready;

    gzmh_parse #(
        .LENGTH_BITS (LENGTH_BITS),
        .POS_BITS    (POS_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .len_flags (len_flags_reg),
        .len_m1    (len_m1_reg),
        .len_m4    (len_m4_reg),
        .len_m8    (len_m8_reg),
        .out_valid (a_valid),
        .out_ready (b_ready),
        .out_ctl   (a_ctl),
        .out_pos   (a_pos),
        .out_size  (a_size)
    );

    // final header length and member status
    always_comb
    begin
        pos_sum   = {1'b0, a_pos} + (POS_BITS + 1)'(a_ctl.pos_add);
        pos_fin   = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
        plen_wide = 64'(len_m8_reg) - 64'(pos_fin);
        priority if (len_lt18_reg)
            status_c = gzmh_pkg::STATUS_SHORT;
        else if (a_ctl.magic_err)
            status_c = gzmh_pkg::STATUS_BAD_MAGIC;
        else if (a_ctl.trunc || pos_fin > POS_BITS'(len_m8_reg))
            status_c = gzmh_pkg::STATUS_TRUNC;
        else
            status_c = gzmh_pkg::STATUS_OK;
        ok_c = a_ctl.done && (status_c == gzmh_pkg::STATUS_OK);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (b_ready)
            m_valid_reg <= a_valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (a_valid && b_ready)
        begin
            byte_reg   <= a_ctl.data;
            kind_reg   <= a_ctl.kind;
            last_reg   <= a_ctl.done;
            status_reg <= a_ctl.done ? status_c : gzmh_pkg::STATUS_OK;
            pstart_reg <= ok_c ? 32'(64'(pos_fin)) : 32'd0;
            plen_reg   <= ok_c ? plen_wide[31:0] : 32'd0;
            isize_reg  <= ok_c ? a_size : 32'd0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, isize_reg, plen_reg, pstart_reg, status_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gzmh_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gzmh_parse #(
    parameter int LENGTH_BITS = 32,
    parameter int POS_BITS    = (LENGTH_BITS >= 63) ? 64 : LENGTH_BITS + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  gzmh_pkg::len_flags_t   len_flags,
    input  logic [LENGTH_BITS-1:0] len_m1,
    input  logic [LENGTH_BITS-1:0] len_m4,
    input  logic [LENGTH_BITS-1:0] len_m8,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gzmh_pkg::item_ctl_t    out_ctl,
    output logic [POS_BITS-1:0]    out_pos,
    output logic [31:0]            out_size
);

    // parse state
    logic [LENGTH_BITS-1:0] idx_reg, idx_next;
    gzmh_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]             flags_reg, flags_next;
    logic [7:0]             skip_reg, skip_next;
    logic [POS_BITS-1:0]    he_reg, he_next;
    logic                   magic_reg, magic_next;
    logic [31:0]            size_reg, size_next;

    // stage register toward the report stage
    logic                   a_valid_reg;
    gzmh_pkg::item_ctl_t    ctl_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [31:0]            asize_reg;

    // values after this item, before the end-of-member clear
    logic [7:0]             flags_upd;
    logic                   magic_upd;
    gzmh_pkg::phase_t       phase_upd;
    gzmh_pkg::phase_t       ent_from;
    logic [7:0]             skip_upd;
    logic [16:0]            inc;
    logic                   go;
    logic [POS_BITS:0]      he_sum;
    logic [POS_BITS-1:0]    he_upd;
    logic [31:0]            size_upd;
    logic                   at_he;
    logic                   done_c;
    logic                   in_fire;
    gzmh_pkg::item_ctl_t    ctl_c;

    // first pending header field at or after a phase
    function automatic gzmh_pkg::phase_t enter_phase(gzmh_pkg::phase_t from,
                                                     logic [7:0] flg);
        gzmh_pkg::phase_t p;
        p = gzmh_pkg::PH_BODY;
        priority if (from <= gzmh_pkg::PH_XLO && flg[gzmh_pkg::FLG_FEXTRA])
            p = gzmh_pkg::PH_XLO;
        else if (from <= gzmh_pkg::PH_NAME && flg[gzmh_pkg::FLG_FNAME])
            p = gzmh_pkg::PH_NAME;
        else if (from <= gzmh_pkg::PH_COMMENT && flg[gzmh_pkg::FLG_FCOMMENT])
            p = gzmh_pkg::PH_COMMENT;
        else
            p = gzmh_pkg::PH_BODY;
        return p;
    endfunction

    assign in_ready = !a_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign at_he    = (POS_BITS'(idx_reg) == he_reg);
    assign done_c   = len_flags.zero || (idx_reg >= len_m1);

    // header field walk for this byte
    always_comb
    begin
        flags_upd = (idx_reg == LENGTH_BITS'(3)) ? in_byte : flags_reg;
        magic_upd = magic_reg
                  | ((idx_reg == LENGTH_BITS'(0)) && (in_byte != gzmh_pkg::MAGIC_ID1))
                  | ((idx_reg == LENGTH_BITS'(1)) && (in_byte != gzmh_pkg::MAGIC_ID2))
                  | ((idx_reg == LENGTH_BITS'(2)) && (in_byte != gzmh_pkg::CM_DEFLATE));
        phase_upd = phase_reg;
        ent_from  = gzmh_pkg::PH_BODY;
        skip_upd  = skip_reg;
        inc       = '0;
        go        = 1'b0;
        unique case (phase_reg)
            gzmh_pkg::PH_FIXED:
            begin
                if (idx_reg == LENGTH_BITS'(gzmh_pkg::FIXED_HDR_LAST))
                begin
                    go       = 1'b1;
                    ent_from = gzmh_pkg::PH_XLO;
                end
            end
            gzmh_pkg::PH_XLO:
            begin
                if (at_he)
                begin
                    skip_upd  = in_byte;
                    inc       = 17'd1;
                    phase_upd = gzmh_pkg::PH_XHI;
                end
            end
            gzmh_pkg::PH_XHI:
            begin
                if (at_he)
                begin
                    inc      = 17'd1 + {1'b0, in_byte, skip_reg};
                    go       = 1'b1;
                    ent_from = gzmh_pkg::PH_NAME;
                end
            end
            gzmh_pkg::PH_NAME, gzmh_pkg::PH_COMMENT:
            begin
                if (at_he)
                begin
                    inc = 17'd1;
                    if (in_byte == 8'd0)
                    begin
                        go       = 1'b1;
                        ent_from = (phase_reg == gzmh_pkg::PH_NAME) ?
                                   gzmh_pkg::PH_COMMENT : gzmh_pkg::PH_BODY;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // entering the body adds the header crc bytes
        if (go)
        begin
            phase_upd = enter_phase(ent_from, flags_upd);
            if (phase_upd == gzmh_pkg::PH_BODY && flags_upd[gzmh_pkg::FLG_FHCRC])
                inc = inc + 17'd2;
        end
        // saturating header end
        he_sum = {1'b0, he_reg} + (POS_BITS + 1)'(inc);
        he_upd = he_sum[POS_BITS] ? '1 : he_sum[POS_BITS-1:0];
        // isize shift from the last four bytes
        size_upd = (!len_flags.lt4 && idx_reg >= len_m4) ?
                   {in_byte, size_reg[31:8]} : size_reg;
    end

    // next state, cleared at the end of a member
    always_comb
    begin
        idx_next   = idx_reg;
        phase_next = phase_reg;
        flags_next = flags_reg;
        skip_next  = skip_reg;
        he_next    = he_reg;
        magic_next = magic_reg;
        size_next  = size_reg;
        if (in_fire)
        begin
            if (done_c)
            begin
                idx_next   = '0;
                phase_next = gzmh_pkg::PH_FIXED;
                flags_next = '0;
                skip_next  = '0;
                he_next    = POS_BITS'(gzmh_pkg::FIXED_HDR_LEN);
                magic_next = 1'b0;
                size_next  = '0;
            end
            else
            begin
                idx_next   = idx_reg + LENGTH_BITS'(1);
                phase_next = phase_upd;
                flags_next = flags_upd;
                skip_next  = skip_upd;
                he_next    = he_upd;
                magic_next = magic_upd;
                size_next  = size_upd;
            end
        end
    end

    // item tag and end-of-member summary inputs
    always_comb
    begin
        ctl_c.data      = in_byte;
        ctl_c.done      = done_c;
        ctl_c.magic_err = magic_upd;
        if (len_flags.lt8 || idx_reg >= len_m8)
            ctl_c.kind = gzmh_pkg::KIND_TRAILER;
        else if (phase_reg != gzmh_pkg::PH_BODY || POS_BITS'(idx_reg) < he_reg)
            ctl_c.kind = gzmh_pkg::KIND_HEADER;
        else
            ctl_c.kind = gzmh_pkg::KIND_PAYLOAD;
        ctl_c.trunc = (phase_upd == gzmh_pkg::PH_FIXED) || (phase_upd == gzmh_pkg::PH_XLO)
                   || (phase_upd == gzmh_pkg::PH_XHI);
        // an open string ends one byte past the member, then the rest follows
        if (phase_upd == gzmh_pkg::PH_NAME || phase_upd == gzmh_pkg::PH_COMMENT)
            ctl_c.pos_add = 3'd1
                + {2'b00, (phase_upd == gzmh_pkg::PH_NAME)
                          && flags_upd[gzmh_pkg::FLG_FCOMMENT]}
                + (flags_upd[gzmh_pkg::FLG_FHCRC] ? 3'd2 : 3'd0);
        else
            ctl_c.pos_add = 3'd0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            phase_reg <= gzmh_pkg::PH_FIXED;
            flags_reg <= '0;
            skip_reg  <= '0;
            he_reg    <= POS_BITS'(gzmh_pkg::FIXED_HDR_LEN);
            magic_reg <= 1'b0;
            size_reg  <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
            he_reg    <= he_next;
            magic_reg <= magic_next;
            size_reg  <= size_next;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ctl_reg   <= ctl_c;
            pos_reg   <= he_upd;
            asize_reg <= size_upd;
        end
    end

    assign out_valid = a_valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_pos   = pos_reg;
    assign out_size  = asize_reg;

    // a finished member leaves the parser at its start state
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && done_c |=> idx_reg == '0 && phase_reg == gzmh_pkg::PH_FIXED)
        else $error("parser state not cleared after final byte");

    // byte index steps by one per accepted non-final byte
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !done_c |=> idx_reg == $past(idx_reg) + LENGTH_BITS'(1))
        else $error("byte index did not advance");

    // index only moves on an accepted byte
    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(idx_reg))
        else $error("byte index moved without an accepted byte");

    // header end never drops below the fixed header
    a_he_floor: assert property (@(posedge clk) disable iff (!rst_n)
        he_reg >= POS_BITS'(gzmh_pkg::FIXED_HDR_LEN))
        else $error("header end below fixed header length");

endmodule

`default_nettype wire
